@@ sv/tdtp_pkg.sv @@
package tdtp_pkg;

    localparam int unsigned ACC_W = 20;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [ACC_W-1:0] HOUR_MAX   = 20'd23;
    localparam logic [ACC_W-1:0] MINSEC_MAX = 20'd59;
    localparam logic [ACC_W-1:0] DAY_MAX    = 20'd31;
    localparam logic [ACC_W-1:0] MONTH_MAX  = 20'd12;
    localparam logic [ACC_W-1:0] YEAR_PIVOT = 20'd80;
    localparam logic [ACC_W-1:0] CENTURY    = 20'd100;
    localparam logic [ACC_W-1:0] YEAR_BASE  = 20'd1900;

    typedef enum logic [2:0] {
        PH_HOUR  = 3'd0,
        PH_MIN   = 3'd1,
        PH_SEC   = 3'd2,
        PH_SKIPT = 3'd3,
        PH_DAY   = 3'd4,
        PH_MON   = 3'd5,
        PH_YEAR  = 3'd6,
        PH_SKIPD = 3'd7
    } t_phase;

    typedef struct packed {
        logic             valid_res;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
        logic [4:0]       day;
        logic [3:0]       month;
        logic [ACC_W-1:0] year_since_1900;
    } t_result;

endpackage

@@ sv/tdtp_if.sv @@
interface tdtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface tdtp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [19:0] year_since_1900;

    modport source (output valid, output valid_res, output hour, output minute,
                    output second, output day, output month, output year_since_1900,
                    input ready);
    modport sink (input valid, input valid_res, input hour, input minute,
                  input second, input day, input month, input year_since_1900,
                  output ready);
endinterface

@@ sv/time_date_text_parser_core.sv @@
// Parses a time text hh:mm[:ss] and then a date text dd/mm/yy[yy], each ended
// by a zero byte, one byte per request on i_in. The zero byte that ends the
// date produces one request on o_res holding the fields, with the month
// counted from zero and the year counted from 1900; valid_res is low and all
// fields are zero when any separator, range or digit-run check failed. A byte
// can be accepted in every cycle while the buffer has space; the only work per
// byte is a multiply-by-ten add into the digit accumulator and a few compares.
// A two-entry result buffer lets bytes keep flowing while a result waits;
// i_in.ready falls only when both entries are held.
module time_date_text_parser_core
    import tdtp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdtp_in_if.sink    i_in,
    tdtp_out_if.source o_res
);

    t_phase           r_phase, n_phase;
    logic [ACC_W-1:0] r_accum, n_accum;
    logic             r_ovf, n_ovf;
    logic             r_bad, n_bad;
    logic [4:0]       r_hour, n_hour;
    logic [5:0]       r_minute, n_minute;
    logic [5:0]       r_second, n_second;
    logic [4:0]       r_day, n_day;
    logic [3:0]       r_month, n_month;

    logic             w_accept;
    logic             w_space;
    logic             w_is_digit;
    logic [ACC_W-1:0] w_acc_next;
    logic             w_sat;
    logic             w_emit;
    logic [ACC_W-1:0] w_yacc;
    logic [ACC_W-1:0] w_year;
    logic             w_ok;
    logic [ACC_W-1:0] w_month_m1;
    t_result          w_res;
    t_result          w_out;

    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid & w_space;
    assign w_is_digit = (i_in.ch >= CH_ZERO) && (i_in.ch <= CH_NINE);
    assign w_month_m1 = r_accum - 20'd1;

    tdtp_digit_acc u_acc (
        .i_accum (r_accum),
        .i_ch    (i_in.ch),
        .o_accum (w_acc_next),
        .o_sat   (w_sat)
    );

    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_ovf    = r_ovf;
        n_bad    = r_bad;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_day    = r_day;
        n_month  = r_month;
        w_emit   = 1'b0;
        w_yacc   = '0;

        if (r_phase != PH_SKIPT && r_phase != PH_SKIPD && w_is_digit) begin
            n_accum = w_acc_next;
            if (w_sat) begin
                n_ovf = 1'b1;
            end
        end else begin
            n_accum = '0;
            unique case (r_phase)
                PH_HOUR: begin
                    n_hour = r_accum[4:0];
                    if (r_accum > HOUR_MAX) begin
                        n_bad = 1'b1;
                    end
                    if (i_in.ch == CH_COLON) begin
                        n_phase = PH_MIN;
                    end else begin
                        n_bad   = 1'b1;
                        n_phase = (i_in.ch == CH_NUL) ? PH_DAY : PH_SKIPT;
                    end
                end
                PH_MIN: begin
                    n_minute = r_accum[5:0];
                    if (r_accum > MINSEC_MAX) begin
                        n_bad = 1'b1;
                    end
                    if (i_in.ch == CH_NUL) begin
                        n_second = '0;
                        n_phase  = PH_DAY;
                    end else if (i_in.ch == CH_COLON) begin
                        n_phase = PH_SEC;
                    end else begin
                        n_bad   = 1'b1;
                        n_phase = PH_SKIPT;
                    end
                end
                PH_SEC: begin
                    n_second = r_accum[5:0];
                    if (r_accum > MINSEC_MAX) begin
                        n_bad = 1'b1;
                    end
                    if (i_in.ch == CH_NUL) begin
                        n_phase = PH_DAY;
                    end else begin
                        n_bad   = 1'b1;
                        n_phase = PH_SKIPT;
                    end
                end
                PH_SKIPT: begin
                    if (i_in.ch == CH_NUL) begin
                        n_phase = PH_DAY;
                    end
                end
                PH_DAY: begin
                    n_day = r_accum[4:0];
                    if (r_accum == '0 || r_accum > DAY_MAX) begin
                        n_bad = 1'b1;
                    end
                    if (i_in.ch == CH_SLASH) begin
                        n_phase = PH_MON;
                    end else begin
                        n_bad = 1'b1;
                        if (i_in.ch == CH_NUL) begin
                            w_emit = 1'b1;
                        end else begin
                            n_phase = PH_SKIPD;
                        end
                    end
                end
                PH_MON: begin
                    n_month = w_month_m1[3:0];
                    if (r_accum == '0 || r_accum > MONTH_MAX) begin
                        n_bad = 1'b1;
                    end
                    if (i_in.ch == CH_SLASH) begin
                        n_phase = PH_YEAR;
                    end else begin
                        n_bad = 1'b1;
                        if (i_in.ch == CH_NUL) begin
                            w_emit = 1'b1;
                        end else begin
                            n_phase = PH_SKIPD;
                        end
                    end
                end
                PH_YEAR: begin
                    if (i_in.ch == CH_NUL) begin
                        w_emit = 1'b1;
                        w_yacc = r_accum;
                    end else begin
                        n_bad   = 1'b1;
                        n_phase = PH_SKIPD;
                    end
                end
                PH_SKIPD: begin
                    if (i_in.ch == CH_NUL) begin
                        n_bad  = 1'b1;
                        w_emit = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HOUR;
                end
            endcase
        end

        // The result is built from the values as updated by this byte.
        w_ok   = ~n_bad & ~n_ovf;
        w_year = '0;
        if (w_yacc < CENTURY) begin
            w_year = (w_yacc < YEAR_PIVOT) ? w_yacc + CENTURY : w_yacc;
        end else if (w_yacc < YEAR_BASE) begin
            w_ok = 1'b0;
        end else begin
            w_year = w_yacc - YEAR_BASE;
        end

        w_res.valid_res       = w_ok;
        w_res.hour            = w_ok ? n_hour   : '0;
        w_res.minute          = w_ok ? n_minute : '0;
        w_res.second          = w_ok ? n_second : '0;
        w_res.day             = w_ok ? n_day    : '0;
        w_res.month           = w_ok ? n_month  : '0;
        w_res.year_since_1900 = w_ok ? w_year   : '0;

        if (w_emit) begin
            n_phase  = PH_HOUR;
            n_accum  = '0;
            n_ovf    = 1'b0;
            n_bad    = 1'b0;
            n_hour   = '0;
            n_minute = '0;
            n_second = '0;
            n_day    = '0;
            n_month  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HOUR;
            r_accum  <= '0;
            r_ovf    <= 1'b0;
            r_bad    <= 1'b0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_day    <= '0;
            r_month  <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_accum  <= n_accum;
            r_ovf    <= n_ovf;
            r_bad    <= n_bad;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_day    <= n_day;
            r_month  <= n_month;
        end
    end

    tdtp_res_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept & w_emit),
        .i_res   (w_res),
        .o_space (w_space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (w_out)
    );

    assign o_res.valid_res       = w_out.valid_res;
    assign o_res.hour            = w_out.hour;
    assign o_res.minute          = w_out.minute;
    assign o_res.second          = w_out.second;
    assign o_res.day             = w_out.day;
    assign o_res.month           = w_out.month;
    assign o_res.year_since_1900 = w_out.year_since_1900;

endmodule

@@ sv/tdtp_digit_acc.sv @@
module tdtp_digit_acc
    import tdtp_pkg::*;
(
    input  logic [ACC_W-1:0] i_accum,
    input  logic [7:0]       i_ch,
    output logic [ACC_W-1:0] o_accum,
    output logic             o_sat
);

    logic [ACC_W+3:0] w_sum;
    logic [3:0]       w_digit;

    // Times ten is eight times plus two times; four spare bits hold the carry.
    assign w_digit = 4'(i_ch - CH_ZERO);
    assign w_sum   = {i_accum, 3'b000} + {2'b00, i_accum, 1'b0} + {20'd0, w_digit};
    assign o_sat   = (w_sum > {4'd0, ACC_MAX});
    assign o_accum = o_sat ? ACC_MAX : w_sum[ACC_W-1:0];

endmodule

@@ sv/tdtp_res_buf.sv @@
module tdtp_res_buf
    import tdtp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    // The skid entry is only filled while the output entry is stalled.
    assign o_space = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule
